// ===== rtl/quaternion_euler_limit_clamp_assert.svh =====
// Assertion macros shared by the RTL. Each macro checks one property on clk,
// disabled while rst is high.
`ifndef QUATERNION_EULER_LIMIT_CLAMP_ASSERT_SVH
`define QUATERNION_EULER_LIMIT_CLAMP_ASSERT_SVH
`ifndef SYNTH
`define QELC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define QELC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define QELC_ASSERT_IMP(label, ante, cons, msg)
`define QELC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/qelc_pkg.sv =====
package qelc_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_COUNT = 24;

  // Datapath widths of the two CORDIC flavors.
  localparam int VXY_W = 36;
  localparam int VZ_W  = 34;
  localparam int RXY_W = 29;
  localparam int RZ_W  = 34;

  // Pipeline depths of the square root and divide sections.
  localparam int ISQ_Y_STG = 15;
  localparam int ISQ_N_STG = 16;
  localparam int DIV_STG   = 8;

  localparam logic signed [33:0] HALF_PI_30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_30      = 34'sd3373259426;
  localparam logic signed [33:0] ONE_28     = 34'sd268435456;
  localparam logic signed [33:0] ANG_RND    = 34'sd65536;
  localparam logic signed [59:0] ONE_56     = 60'sh100000000000000;
  localparam logic signed [RXY_W-1:0] ROT_START = 29'sd67108864;

  // Configuration register indexes.
  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MAX_X = 3'd1;
  localparam logic [2:0] REG_MIN_Y = 3'd2;
  localparam logic [2:0] REG_MAX_Y = 3'd3;
  localparam logic [2:0] REG_MIN_Z = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

  localparam logic signed [15:0] LIM_LO_RST = -16'sd25736;
  localparam logic signed [15:0] LIM_HI_RST = 16'sd25736;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
  } isq_t;

  typedef struct packed {
    logic signed [VXY_W-1:0] x;
    logic signed [VXY_W-1:0] y;
    logic signed [VZ_W-1:0]  z;
    logic                    zero;
  } vpre_t;

  // atan(2^-i) at scale 2^30, rounded down.
  function automatic logic [31:0] atan_tab(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // One digit of a restoring square root: two radicand bits in, one root bit out.
  function automatic isq_t isq_step(input isq_t s, input logic [1:0] b);
    logic [35:0] r;
    logic [35:0] t;
    isq_t o;
    r = {s.rem[33:0], b};
    t = {2'b00, s.root, 2'b01};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // Brings a vectoring operand into the right half plane.
  function automatic vpre_t vec_pre(input logic signed [VXY_W-1:0] x,
                                    input logic signed [VXY_W-1:0] y);
    vpre_t o;
    o.zero = (x == '0) && (y == '0);
    o.x = x;
    o.y = y;
    o.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        o.x = y;
        o.y = -x;
        o.z = HALF_PI_30;
      end else begin
        o.x = -y;
        o.y = x;
        o.z = -HALF_PI_30;
      end
    end
    return o;
  endfunction

endpackage

// ===== rtl/quaternion_euler_limit_clamp.sv =====
// Throughput: one item per cycle unless the pipe halts; every stage is a register
// and the whole pipe advances together. The pipe halts only while a finished result
// sits at the output and out_stall is high.
// Reset (rst, synchronous, active high) empties the pipe and loads the angle limits
// with -25736 (minimum) and 25736 (maximum) on every axis.
module quaternion_euler_limit_clamp #(
  parameter int CORDIC_STAGES = qelc_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_w,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic signed [15:0] in_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_w,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Stage budget: three input stages, the asin square root, the vectoring
  // prologue, two angle stages, the negate stage, five product stages, the
  // norm square root, the divide prologue, the divider and the output stage.
  localparam int LAT = 14 + qelc_pkg::ISQ_Y_STG + qelc_pkg::ISQ_N_STG
                     + qelc_pkg::DIV_STG + 2 * CORDIC_STAGES;
  localparam int VXW = qelc_pkg::VXY_W;
  localparam int VZW = qelc_pkg::VZ_W;
  localparam int RXW = qelc_pkg::RXY_W;
  localparam int RZW = qelc_pkg::RZ_W;
  localparam int NY  = qelc_pkg::ISQ_Y_STG;
  localparam int NN  = qelc_pkg::ISQ_N_STG;
  localparam int ND  = qelc_pkg::DIV_STG;

  // ---------------------------------------------------------------------------
  // Flow control. All stages share one enable, so data and valid bits move in
  // lock step. The pipe moves whenever the output register is empty or is
  // being taken, so a stall never drops or duplicates an item.
  // ---------------------------------------------------------------------------
  logic [LAT-1:0] vld;
  logic           adv;

  assign adv       = !vld[LAT-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Angle limit registers, a min/max pair per axis in Q3.13 radians.
  // Writes to indexes past the last register are dropped.
  // ---------------------------------------------------------------------------
  logic signed [15:0] lim [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      lim[qelc_pkg::REG_MIN_X] <= qelc_pkg::LIM_LO_RST;
      lim[qelc_pkg::REG_MAX_X] <= qelc_pkg::LIM_HI_RST;
      lim[qelc_pkg::REG_MIN_Y] <= qelc_pkg::LIM_LO_RST;
      lim[qelc_pkg::REG_MAX_Y] <= qelc_pkg::LIM_HI_RST;
      lim[qelc_pkg::REG_MIN_Z] <= qelc_pkg::LIM_LO_RST;
      lim[qelc_pkg::REG_MAX_Z] <= qelc_pkg::LIM_HI_RST;
    end else if (cfg_we && cfg_index <= qelc_pkg::REG_MAX_Z) begin
      lim[cfg_index] <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the nine component products of the quaternion, exact at 2^28.
  // ---------------------------------------------------------------------------
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_wx <= in_w * in_x;
      p_yz <= in_y * in_z;
      p_xx <= in_x * in_x;
      p_yy <= in_y * in_y;
      p_wy <= in_w * in_y;
      p_zx <= in_z * in_x;
      p_wz <= in_w * in_z;
      p_xy <= in_x * in_y;
      p_zz <= in_z * in_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: atan2 operands for the x and z angles, and the asin argument for
  // y, which saturates to plus or minus one.
  // ---------------------------------------------------------------------------
  logic signed [33:0] sum_x, sq_x, sum_z, sq_z, dif_y, s_wide, s_sat;
  logic signed [33:0] s1_numx, s1_denx, s1_numz, s1_denz;
  logic signed [29:0] s1_s;

  always_comb begin
    sum_x  = 34'(p_wx) + 34'(p_yz);
    sq_x   = 34'(p_xx) + 34'(p_yy);
    sum_z  = 34'(p_wz) + 34'(p_xy);
    sq_z   = 34'(p_yy) + 34'(p_zz);
    dif_y  = 34'(p_wy) - 34'(p_zx);
    s_wide = dif_y <<< 1;
    if (s_wide > qelc_pkg::ONE_28) begin
      s_sat = qelc_pkg::ONE_28;
    end else if (s_wide < -qelc_pkg::ONE_28) begin
      s_sat = -qelc_pkg::ONE_28;
    end else begin
      s_sat = s_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_numx <= sum_x <<< 1;
      s1_denx <= qelc_pkg::ONE_28 - (sq_x <<< 1);
      s1_numz <= sum_z <<< 1;
      s1_denz <= qelc_pkg::ONE_28 - (sq_z <<< 1);
      s1_s    <= 30'(s_sat);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 and the asin square root: cos(y) = sqrt(1 - s^2) at scale 2^28.
  // Two root bits per stage; the x and z operands ride along.
  // ---------------------------------------------------------------------------
  logic signed [59:0] ssq;
  qelc_pkg::isq_t     iy_st [NY+1];
  logic [59:0]        iy_v  [NY+1];
  logic signed [33:0] iy_nx [NY+1];
  logic signed [33:0] iy_dx [NY+1];
  logic signed [33:0] iy_nz [NY+1];
  logic signed [33:0] iy_dz [NY+1];
  logic signed [29:0] iy_s  [NY+1];

  assign ssq = s1_s * s1_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      iy_st[0] <= '0;
      iy_v[0]  <= 60'(qelc_pkg::ONE_56 - ssq);
      iy_nx[0] <= s1_numx;
      iy_dx[0] <= s1_denx;
      iy_nz[0] <= s1_numz;
      iy_dz[0] <= s1_denz;
      iy_s[0]  <= s1_s;
    end
  end

  for (genvar k = 0; k < NY; k++) begin : g_isq_y
    qelc_pkg::isq_t st_a, st_b;
    always_comb begin
      st_a = qelc_pkg::isq_step(iy_st[k], iy_v[k][59:58]);
      st_b = qelc_pkg::isq_step(st_a, iy_v[k][57:56]);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        iy_st[k+1] <= st_b;
        iy_v[k+1]  <= iy_v[k] << 4;
        iy_nx[k+1] <= iy_nx[k];
        iy_dx[k+1] <= iy_dx[k];
        iy_nz[k+1] <= iy_nz[k];
        iy_dz[k+1] <= iy_dz[k];
        iy_s[k+1]  <= iy_s[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Vectoring prologue and three vectoring CORDICs, one per axis. A zero
  // operand pair is flagged here and forces a zero angle afterwards.
  // ---------------------------------------------------------------------------
  logic signed [VXW-1:0] vx_op [3];
  logic signed [VXW-1:0] vy_op [3];
  qelc_pkg::vpre_t       vp    [3];
  logic                  vz_flag [3];
  logic signed [VXW-1:0] vx_o [3];
  logic signed [VXW-1:0] vy_o [3];
  logic signed [VZW-1:0] vz_o [3];

  assign vx_op[0] = VXW'(iy_dx[NY]);
  assign vy_op[0] = VXW'(iy_nx[NY]);
  assign vx_op[1] = VXW'(iy_st[NY].root);
  assign vy_op[1] = VXW'(iy_s[NY]);
  assign vx_op[2] = VXW'(iy_dz[NY]);
  assign vy_op[2] = VXW'(iy_nz[NY]);

  // Angle stage A1 and A2 registers.
  logic signed [16:0]    a1_ang [3];
  logic signed [RZW-1:0] rp_z   [3];
  logic                  rp_neg [3];
  logic signed [RXW-1:0] rx_o   [3];
  logic signed [RXW-1:0] ry_o   [3];
  logic signed [RZW-1:0] rz_o   [3];
  logic                  r_neg  [3];
  logic signed [RXW-1:0] nc     [3];
  logic signed [RXW-1:0] ns     [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [33:0] z_rnd;
    logic signed [16:0] ang, lo, hi, clmp;
    logic signed [33:0] h;

    always_ff @(posedge clk) begin
      if (adv) begin
        vp[a] <= qelc_pkg::vec_pre(vx_op[a], vy_op[a]);
      end
    end

    qelc_cordic #(
      .STAGES (CORDIC_STAGES),
      .VEC    (1'b1),
      .XY_W   (VXW),
      .Z_W    (VZW)
    ) u_vec (
      .clk     (clk),
      .en      (adv),
      .tag_in  (vp[a].zero),
      .x_in    (vp[a].x),
      .y_in    (vp[a].y),
      .z_in    (vp[a].z),
      .tag_out (vz_flag[a]),
      .x_out   (vx_o[a]),
      .y_out   (vy_o[a]),
      .z_out   (vz_o[a])
    );

    // Round the angle to Q3.13, then clamp; max is applied after min, so a
    // crossed window yields the maximum.
    always_comb begin
      z_rnd = vz_o[a] + qelc_pkg::ANG_RND;
      ang   = vz_flag[a] ? '0 : 17'(z_rnd >>> 17);
      lo    = 17'(lim[2*a]);
      hi    = 17'(lim[2*a+1]);
      clmp  = ang;
      if (clmp < lo) begin
        clmp = lo;
      end
      if (clmp > hi) begin
        clmp = hi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a1_ang[a] <= clmp;
      end
    end

    // Half angle at scale 2^30, folded into the CORDIC's range by pi.
    assign h = 34'(a1_ang[a]) <<< 16;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (h > qelc_pkg::HALF_PI_30) begin
          rp_z[a]   <= RZW'(h - qelc_pkg::PI_30);
          rp_neg[a] <= 1'b1;
        end else if (h < -qelc_pkg::HALF_PI_30) begin
          rp_z[a]   <= RZW'(h + qelc_pkg::PI_30);
          rp_neg[a] <= 1'b1;
        end else begin
          rp_z[a]   <= RZW'(h);
          rp_neg[a] <= 1'b0;
        end
      end
    end

    qelc_cordic #(
      .STAGES (CORDIC_STAGES),
      .VEC    (1'b0),
      .XY_W   (RXW),
      .Z_W    (RZW)
    ) u_rot (
      .clk     (clk),
      .en      (adv),
      .tag_in  (rp_neg[a]),
      .x_in    (qelc_pkg::ROT_START),
      .y_in    ('0),
      .z_in    (rp_z[a]),
      .tag_out (r_neg[a]),
      .x_out   (rx_o[a]),
      .y_out   (ry_o[a]),
      .z_out   (rz_o[a])
    );

    // The residual angle is not needed; cos and sin flip sign after a pi fold.
    always_ff @(posedge clk) begin
      if (adv) begin
        nc[a] <= r_neg[a] ? -rx_o[a] : rx_o[a];
        ns[a] <= r_neg[a] ? -ry_o[a] : ry_o[a];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Quaternion rebuild: pair products, triple products, then the sums. Pair
  // products and sums are floored by 2^26. The CORDIC gain is common to all four terms.
  // ---------------------------------------------------------------------------
  logic signed [57:0] pr_cc, pr_ss, pr_sc, pr_cs;
  logic signed [29:0] m1_cxcy, m1_sxsy, m1_sxcy, m1_cxsy;
  logic signed [RXW-1:0] m1_cz, m1_sz;
  logic signed [58:0] t_w1, t_w2, t_x1, t_x2, t_y1, t_y2, t_z1, t_z2;
  logic signed [59:0] sm_w, sm_x, sm_y, sm_z;
  logic signed [30:0] m3_q [4];
  logic signed [61:0] m4_sq [4];
  logic signed [30:0] m4_q  [4];

  assign pr_cc = nc[0] * nc[1];
  assign pr_ss = ns[0] * ns[1];
  assign pr_sc = ns[0] * nc[1];
  assign pr_cs = nc[0] * ns[1];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_cxcy <= pr_cc[55:26];
      m1_sxsy <= pr_ss[55:26];
      m1_sxcy <= pr_sc[55:26];
      m1_cxsy <= pr_cs[55:26];
      m1_cz   <= nc[2];
      m1_sz   <= ns[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_w1 <= m1_cxcy * m1_cz;
      t_w2 <= m1_sxsy * m1_sz;
      t_x1 <= m1_sxcy * m1_cz;
      t_x2 <= m1_cxsy * m1_sz;
      t_y1 <= m1_cxsy * m1_cz;
      t_y2 <= m1_sxcy * m1_sz;
      t_z1 <= m1_cxcy * m1_sz;
      t_z2 <= m1_sxsy * m1_cz;
    end
  end

  assign sm_w = 60'(t_w1) + 60'(t_w2);
  assign sm_x = 60'(t_x1) - 60'(t_x2);
  assign sm_y = 60'(t_y1) + 60'(t_y2);
  assign sm_z = 60'(t_z1) - 60'(t_z2);

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_q[0] <= sm_w[56:26];
      m3_q[1] <= sm_x[56:26];
      m3_q[2] <= sm_y[56:26];
      m3_q[3] <= sm_z[56:26];
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_square
    always_ff @(posedge clk) begin
      if (adv) begin
        m4_sq[c] <= m3_q[c] * m3_q[c];
        m4_q[c]  <= m3_q[c];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Norm: square root of the sum of squares, two root bits per stage.
  // ---------------------------------------------------------------------------
  qelc_pkg::isq_t     iq_st [NN+1];
  logic [63:0]        iq_v  [NN+1];
  logic signed [30:0] iq_q  [NN+1][4];

  always_ff @(posedge clk) begin
    if (adv) begin
      iq_st[0] <= '0;
      iq_v[0]  <= 64'(m4_sq[0]) + 64'(m4_sq[1]) + 64'(m4_sq[2]) + 64'(m4_sq[3]);
      iq_q[0]  <= m4_q;
    end
  end

  for (genvar k = 0; k < NN; k++) begin : g_isq_n
    qelc_pkg::isq_t st_a, st_b;
    always_comb begin
      st_a = qelc_pkg::isq_step(iq_st[k], iq_v[k][63:62]);
      st_b = qelc_pkg::isq_step(st_a, iq_v[k][61:60]);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        iq_st[k+1] <= st_b;
        iq_v[k+1]  <= iq_v[k] << 4;
        iq_q[k+1]  <= iq_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Normalizing divide: round(|q| * 2^14 / n), restoring, two quotient bits
  // per stage. The quotient never exceeds 2^14 because |q| <= n.
  // ---------------------------------------------------------------------------
  logic [31:0] n_root;
  logic [32:0] dv_rem [ND+1][4];
  logic [15:0] dv_lo  [ND+1][4];
  logic [15:0] dv_q   [ND+1][4];
  logic        dv_neg [ND+1][4];
  logic [31:0] dv_n   [ND+1];
  logic        dv_nz  [ND+1];

  assign n_root = iq_st[NN].root;

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_n[0]  <= n_root;
      dv_nz[0] <= (n_root == '0);
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_div_in
    logic [30:0] mag;
    logic [45:0] num;
    always_comb begin
      mag = iq_q[NN][c][30] ? 31'(-iq_q[NN][c]) : 31'(iq_q[NN][c]);
      num = (46'(mag) << 14) + 46'(n_root[31:1]);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[0][c] <= 33'(num[45:16]);
        dv_lo[0][c]  <= num[15:0];
        dv_q[0][c]   <= '0;
        dv_neg[0][c] <= iq_q[NN][c][30];
      end
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_n[k+1]  <= dv_n[k];
        dv_nz[k+1] <= dv_nz[k];
      end
    end
    for (genvar c = 0; c < 4; c++) begin : g_lane
      logic [32:0] r1, r2, d1, d2, nn;
      logic        g1, g2;
      always_comb begin
        nn = 33'(dv_n[k]);
        r1 = {dv_rem[k][c][31:0], dv_lo[k][c][15]};
        g1 = (r1 >= nn);
        d1 = g1 ? r1 - nn : r1;
        r2 = {d1[31:0], dv_lo[k][c][14]};
        g2 = (r2 >= nn);
        d2 = g2 ? r2 - nn : r2;
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem[k+1][c] <= d2;
          dv_lo[k+1][c]  <= dv_lo[k][c] << 2;
          dv_q[k+1][c]   <= {dv_q[k][c][13:0], g1, g2};
          dv_neg[k+1][c] <= dv_neg[k][c];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: restore the signs; a zero norm gives the identity.
  // ---------------------------------------------------------------------------
  logic signed [15:0] res [4];

  for (genvar c = 0; c < 4; c++) begin : g_out
    always_comb begin
      if (dv_nz[ND]) begin
        res[c] = (c == 0) ? 16'sd16384 : 16'sd0;
      end else if (dv_neg[ND][c]) begin
        res[c] = -dv_q[ND][c];
      end else begin
        res[c] = dv_q[ND][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_w <= res[0];
      out_x <= res[1];
      out_y <= res[2];
      out_z <= res[3];
    end
  end

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `include "quaternion_euler_limit_clamp_assert.svh"

  `QELC_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld[0], "accepted item lost")
  `QELC_ASSERT_NXT(a_hold_on_stall, !adv, $stable(vld), "valid bits moved while held")
  `QELC_ASSERT_IMP(a_range_w, out_valid, out_w <= 16'sd16384 && out_w >= -16'sd16384, "out_w range")
  `QELC_ASSERT_IMP(a_range_x, out_valid, out_x <= 16'sd16384 && out_x >= -16'sd16384, "out_x range")
  `QELC_ASSERT_IMP(a_range_y, out_valid, out_y <= 16'sd16384 && out_y >= -16'sd16384, "out_y range")
  `QELC_ASSERT_IMP(a_range_z, out_valid, out_z <= 16'sd16384 && out_z >= -16'sd16384, "out_z range")

endmodule

// ===== rtl/qelc_cordic.sv =====
module qelc_cordic #(
  parameter int STAGES = qelc_pkg::CORDIC_STAGES_DEF,
  parameter bit VEC    = 1'b1,
  parameter int XY_W   = qelc_pkg::VXY_W,
  parameter int Z_W    = qelc_pkg::VZ_W
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic                   tag_in,
  input  logic signed [XY_W-1:0] x_in,
  input  logic signed [XY_W-1:0] y_in,
  input  logic signed [Z_W-1:0]  z_in,
  output logic                   tag_out,
  output logic signed [XY_W-1:0] x_out,
  output logic signed [XY_W-1:0] y_out,
  output logic signed [Z_W-1:0]  z_out
);

  logic signed [XY_W-1:0] xs [STAGES+1];
  logic signed [XY_W-1:0] ys [STAGES+1];
  logic signed [Z_W-1:0]  zs [STAGES+1];
  logic                   ts [STAGES+1];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;
  assign ts[0] = tag_in;

  // One micro-rotation per register stage. Vectoring drives y toward zero,
  // rotation drives the residual angle toward zero.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] AT = Z_W'(qelc_pkg::atan_tab(i));
    logic ccw;
    assign ccw = VEC ? ys[i][XY_W-1] : !zs[i][Z_W-1];
    always_ff @(posedge clk) begin
      if (en) begin
        xs[i+1] <= ccw ? xs[i] - (ys[i] >>> i) : xs[i] + (ys[i] >>> i);
        ys[i+1] <= ccw ? ys[i] + (xs[i] >>> i) : ys[i] - (xs[i] >>> i);
        zs[i+1] <= ccw ? zs[i] - AT : zs[i] + AT;
        ts[i+1] <= ts[i];
      end
    end
  end

  assign x_out   = xs[STAGES];
  assign y_out   = ys[STAGES];
  assign z_out   = zs[STAGES];
  assign tag_out = ts[STAGES];

endmodule

// ===== test/quaternion_euler_limit_clamp_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the Euler-angle limiter.
// A driver pushes quaternion items from a pending queue, and a monitor compares
// every result with the oldest expected quaternion. The expected quaternion is
// worked out in the bench from the same CORDIC arithmetic the block uses.
module quaternion_euler_limit_clamp_tb;

  localparam int STAGES    = 16;
  localparam int DRAIN     = 200;   // Comfortably past the pipe depth.
  localparam int WDOG_MAX  = 5000;
  localparam longint HPI   = 64'sd1686629713;
  localparam longint PI    = 64'sd3373259426;
  localparam longint ONE28 = 64'sd268435456;

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_item_t;

  typedef logic [3:0][15:0] quat_bits_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_w = '0, in_x = '0, in_y = '0, in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_w, out_x, out_y, out_z;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = qelc_pkg::REG_MIN_X;
  logic [15:0] cfg_data = '0;

  // Angle windows as the block should hold them, in register order.
  logic signed [15:0] lim[6];

  quat_item_t pending[$];
  quat_bits_t expected_quats[$];
  quat_item_t cur_item;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int idle_cycles = 0;

  longint atan_steps[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
    8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  string field_names[4] = '{"out_z", "out_y", "out_x", "out_w"};

  quaternion_euler_limit_clamp u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_w(in_w), .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Exact floor square root, one bit pair per pass.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC: angle of (xx, yy) in Q3.13 radians.
  function automatic longint vector_angle(longint yy, longint xx);
    longint ang, t, xs, ys;
    ang = 0;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      if (yy >= 0) begin
        t = xx; xx = yy; yy = -t; ang = HPI;
      end else begin
        t = xx; xx = -yy; yy = t; ang = -HPI;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = xx >>> i;
      ys = yy >>> i;
      if (yy < 0) begin
        xx = xx - ys; yy = yy + xs; ang -= atan_steps[i];
      end else begin
        xx = xx + ys; yy = yy - xs; ang += atan_steps[i];
      end
    end
    return (ang + 64'sd65536) >>> 17;
  endfunction

  // Rotation CORDIC: unscaled cosine and sine of a half angle at scale 2^30.
  function automatic void half_cos_sin(input longint a, output longint c, output longint s);
    longint xx, yy, xs, ys;
    bit flip;
    xx = 64'sd67108864;
    yy = 0;
    flip = 1'b0;
    if (a > HPI) begin
      a -= PI; flip = 1'b1;
    end else if (a < -HPI) begin
      a += PI; flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = xx >>> i;
      ys = yy >>> i;
      if (a >= 0) begin
        xx = xx - ys; yy = yy + xs; a -= atan_steps[i];
      end else begin
        xx = xx + ys; yy = yy - xs; a += atan_steps[i];
      end
    end
    c = flip ? -xx : xx;
    s = flip ? -yy : yy;
  endfunction

  // Limits an angle to its window (maximum wins when crossed), then halves it.
  function automatic longint window_half(longint a, int axis);
    if (a < longint'(lim[2*axis])) a = lim[2*axis];
    if (a > longint'(lim[2*axis+1])) a = lim[2*axis+1];
    return a * 65536;
  endfunction

  function automatic logic [15:0] unit_scale(longint c, longint unsigned n);
    longint unsigned m, q;
    m = (c < 0) ? longint'(-c) : c;
    q = ((m << 14) + (n >> 1)) / n;
    if (c < 0) q = 64'd0 - q;
    return q[15:0];
  endfunction

  function automatic quat_bits_t clamp_quaternion(quat_item_t it);
    longint w, x, y, z, ax, ay, az, s, cx, sx, cy, sy, cz, sz;
    longint cxcy, sxsy, sxcy, cxsy, qw, qx, qy, qz;
    longint unsigned n2, n;
    quat_bits_t r;
    w = it.w; x = it.x; y = it.y; z = it.z;
    ax = vector_angle(2 * (w * x + y * z), ONE28 - 2 * (x * x + y * y));
    s = 2 * (w * y - z * x);
    if (s > ONE28) s = ONE28;
    if (s < -ONE28) s = -ONE28;
    ay = vector_angle(s, longint'(root_floor(ONE28 * ONE28 - s * s)));
    az = vector_angle(2 * (w * z + x * y), ONE28 - 2 * (y * y + z * z));
    half_cos_sin(window_half(ax, 0), cx, sx);
    half_cos_sin(window_half(ay, 1), cy, sy);
    half_cos_sin(window_half(az, 2), cz, sz);
    cxcy = (cx * cy) >>> 26;
    sxsy = (sx * sy) >>> 26;
    sxcy = (sx * cy) >>> 26;
    cxsy = (cx * sy) >>> 26;
    qw = (cxcy * cz + sxsy * sz) >>> 26;
    qx = (sxcy * cz - cxsy * sz) >>> 26;
    qy = (cxsy * cz + sxcy * sz) >>> 26;
    qz = (cxcy * sz - sxsy * cz) >>> 26;
    n2 = qw * qw + qx * qx + qy * qy + qz * qz;
    n = root_floor(n2);
    // A vanishing norm falls back to the identity rotation.
    if (n == 0) return {16'd16384, 16'd0, 16'd0, 16'd0};
    r = {unit_scale(qw, n), unit_scale(qx, n), unit_scale(qy, n), unit_scale(qz, n)};
    return r;
  endfunction

  // Driver: on acceptance, predict the result of the item just taken, then
  // offer the next pending item unless this cycle is chosen to idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_quats.push_back(clamp_quaternion(cur_item));
      if (!in_valid || !in_stall) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending.pop_front();
          in_valid <= 1'b1;
          in_w <= cur_item.w;
          in_x <= cur_item.x;
          in_y <= cur_item.y;
          in_z <= cur_item.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation and
  // picks the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_quats.size() == 0) begin
          $error("result item with no expectation pending");
          fail_count++;
        end else begin
          quat_bits_t exp_q, got_q;
          exp_q = expected_quats.pop_front();
          got_q = {out_w, out_x, out_y, out_z};
          for (int k = 0; k < 4; k++) begin
            if (exp_q[k] !== got_q[k]) begin
              $error("%s expected %0d got %0d", field_names[k],
                     $signed(exp_q[k]), $signed(got_q[k]));
              fail_count++;
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_MAX) begin
      $display("quaternion_euler_limit_clamp_tb NOT OK");
      $finish;
    end
  end

  task automatic add_item(int w, int x, int y, int z);
    quat_item_t it;
    it.w = w; it.x = x; it.y = y; it.z = z;
    pending.push_back(it);
  endtask

  // Random mix: mostly in-range components, some landmark values, some raw noise.
  function automatic int rand_component(int mode);
    int picks[9] = '{0, 16384, -16384, 11585, -11585, 8192, -8192, 32767, -32768};
    if (mode < 80) return int'($urandom_range(32768)) - 16384;
    if (mode < 90) return picks[$urandom_range(8)];
    return int'($signed(16'($urandom_range(65535))));
  endfunction

  task automatic add_random(int count);
    int mode;
    repeat (count) begin
      mode = $urandom_range(99);
      add_item(rand_component(mode), rand_component(mode),
               rand_component(mode), rand_component(mode));
    end
  endtask

  // Waits until every item has been taken and every result has come back,
  // then lets the pipe drain fully.
  task automatic wait_drained();
    while (pending.size() > 0 || in_valid || expected_quats.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_limits(int mnx, int mxx, int mny, int mxy, int mnz, int mxz);
    int vals[6];
    vals = '{mnx, mxx, mny, mxy, mnz, mxz};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= 16'(vals[i]);
      lim[i] = 16'(vals[i]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_limit();
    return int'($urandom_range(51472)) - 25736;
  endfunction

  initial begin
    lim = '{qelc_pkg::LIM_LO_RST, qelc_pkg::LIM_HI_RST, qelc_pkg::LIM_LO_RST,
            qelc_pkg::LIM_HI_RST, qelc_pkg::LIM_LO_RST, qelc_pkg::LIM_HI_RST};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed items under reset limits, with no idling on either side.
    add_item(16384, 0, 0, 0);             // identity
    add_item(0, 0, 0, 0);                 // all-zero quaternion
    add_item(-16384, 0, 0, 0);
    add_item(0, 16384, 0, 0);             // half turns about each axis
    add_item(0, 0, 16384, 0);
    add_item(0, 0, 0, 16384);
    add_item(0, -16384, 0, 0);
    add_item(0, 0, -16384, 0);
    add_item(0, 0, 0, -16384);
    add_item(0, 8192, 8192, 0);           // x angle from a zero vector
    add_item(0, 0, 8192, 8192);           // z angle from a zero vector
    add_item(11585, 0, 11585, 0);         // gimbal lock, sine at plus one
    add_item(11585, 0, -11585, 0);        // gimbal lock, sine at minus one
    add_item(16384, 0, 16384, 0);         // sine past one, saturates
    add_item(-16384, 16384, 16384, -16384);
    add_item(32767, 32767, 32767, 32767); // out-of-range extremes
    add_item(-32768, -32768, -32768, -32768);
    add_item(-32768, 32767, -32768, 32767);
    add_item(8192, 8192, 8192, 8192);
    add_item(-8192, 8192, -8192, 8192);
    add_random(300);
    wait_drained();

    // Random windows; sender mostly idle.
    write_limits(rand_limit(), rand_limit(), rand_limit(), rand_limit(),
                 rand_limit(), rand_limit());
    send_idle_pct = 72;
    add_random(350);
    wait_drained();

    // Crossed windows and zero-width windows; receiver mostly stalled.
    write_limits(25736, -25736, 0, 0, 4000, -4000);
    send_idle_pct = 0;
    recv_stall_pct = 72;
    add_random(350);
    wait_drained();

    // Raw register values over the whole 16-bit range; light idling both sides.
    write_limits(-32768, 32767, int'($urandom_range(65535)), int'($urandom_range(65535)),
                 int'($urandom_range(65535)), int'($urandom_range(65535)));
    send_idle_pct = 11;
    recv_stall_pct = 11;
    add_random(350);
    wait_drained();

    // Narrow windows near the extremes for x and y, near zero for z; the sender
    // pauses midway until all results are back, then finishes the phase.
    write_limits(25000, 25736, -25736, -25000, -100, 100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random(250);
    while (pending.size() > 0 || in_valid || expected_quats.size() > 0) @(posedge clk);
    add_random(250);
    wait_drained();

    if (fail_count == 0) begin
      $display("quaternion_euler_limit_clamp_tb OK");
    end else begin
      $display("quaternion_euler_limit_clamp_tb NOT OK");
    end
    $finish;
  end

endmodule
